// ===== rtl/bmie_pkg.sv =====
// Shared types, codes and constants for the byte memory instruction executor.
`default_nettype none
package bmie_pkg;

    localparam int MEM_DEPTH_DEF = 256;
    localparam int MAX_VARS_DEF  = 64;

    localparam int BYTE_W = 8;
    localparam int OPC_W  = 4;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [OPC_W-1:0] OP_ADD = 4'd0;
    localparam logic [OPC_W-1:0] OP_SUB = 4'd1;
    localparam logic [OPC_W-1:0] OP_DIV = 4'd2;
    localparam logic [OPC_W-1:0] OP_MUL = 4'd3;
    localparam logic [OPC_W-1:0] OP_MOD = 4'd4;
    localparam logic [OPC_W-1:0] OP_SET = 4'd5;

    localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VAR    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IMM    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIVZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    // pointer load sources
    localparam logic [1:0] PTR_OPND = 2'd0;
    localparam logic [1:0] PTR_ZERO = 2'd1;
    localparam logic [1:0] PTR_VAR  = 2'd2;

    // register word index
    localparam logic REG_FIRST_VAR = 1'b0;

    localparam logic [BYTE_W-1:0] FIRST_VAR_RST = 8'd0;

    typedef struct packed {
        logic               cap;        // latch operands
        logic               sel_src;    // 0: destination side, 1: source side
        logic               var_rd;
        logic               var_alloc;
        logic               ld_ptr;
        logic [1:0]         ptr_src;
        logic               mem_rd;
        logic               ld_b;
        logic               ld_b_imm;
        logic               ld_a;
        logic               div_start;
        logic               alu_ld;
        logic [OPC_W-1:0]   op;
        logic               out_ld;
        logic               mem_wr;
        logic [STAT_W-1:0]  status;
    } t_dp_cmd;

    typedef struct packed {
        logic dst_hit;
        logic src_hit;
        logic full;
        logic b_zero;
        logic div_busy;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== rtl/bmie_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module bmie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bmie_ctrl.sv =====
// Instruction sequencer: steps each item through lookup, reads, ALU and write.
`default_nettype none
module bmie_ctrl
    import bmie_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [OPC_W-1:0]  i_action,
    input  wire logic [MODE_W-1:0] i_dest_mode,
    input  wire logic [MODE_W-1:0] i_src_mode,
    input  wire t_dp_sts           i_sts,
    output t_dp_cmd                o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DST  = 4'd1;
    localparam logic [3:0] S_DSTV = 4'd2;
    localparam logic [3:0] S_SRC  = 4'd3;
    localparam logic [3:0] S_SRCV = 4'd4;
    localparam logic [3:0] S_RDB  = 4'd5;
    localparam logic [3:0] S_LDB  = 4'd6;
    localparam logic [3:0] S_RDA  = 4'd7;
    localparam logic [3:0] S_LDA  = 4'd8;
    localparam logic [3:0] S_EXE  = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0]        r_state, n_state;
    logic [OPC_W-1:0]  r_act;
    logic [MODE_W-1:0] r_dm, r_sm;
    logic [STAT_W-1:0] r_st, n_st;
    logic              r_wr, n_wr;
    logic              accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        n_wr    = r_wr;
        o_cmd   = '0;
        o_cmd.op     = r_act;
        o_cmd.status = r_st;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.cap = 1'b1;
                    if (i_action > OP_SET) begin
                        n_st    = ST_OK;
                        n_wr    = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_DST;
                    end
                end
            end
            S_DST: begin
                o_cmd.sel_src = 1'b0;
                n_state       = S_SRC;
                case (r_dm)
                    MODE_VAR: begin
                        if (i_sts.dst_hit) begin
                            o_cmd.var_rd = 1'b1;
                            n_state      = S_DSTV;
                        end else if (i_sts.full) begin
                            n_st    = ST_FULL;
                            n_wr    = 1'b0;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.var_alloc = 1'b1;
                        end
                    end
                    MODE_NONE: begin
                        o_cmd.ld_ptr  = 1'b1;
                        o_cmd.ptr_src = PTR_ZERO;
                    end
                    default: begin
                        o_cmd.ld_ptr  = 1'b1;
                        o_cmd.ptr_src = PTR_OPND;
                    end
                endcase
            end
            S_DSTV: begin
                o_cmd.sel_src = 1'b0;
                o_cmd.ld_ptr  = 1'b1;
                o_cmd.ptr_src = PTR_VAR;
                n_state       = S_SRC;
            end
            S_SRC: begin
                o_cmd.sel_src = 1'b1;
                case (r_sm)
                    MODE_DIRECT: begin
                        o_cmd.ld_ptr  = 1'b1;
                        o_cmd.ptr_src = PTR_OPND;
                        n_state       = S_RDB;
                    end
                    MODE_VAR: begin
                        if (i_sts.src_hit) begin
                            o_cmd.var_rd = 1'b1;
                            n_state      = S_SRCV;
                        end else if (i_sts.full) begin
                            n_st    = ST_FULL;
                            n_wr    = 1'b0;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.var_alloc = 1'b1;
                            n_state         = S_RDB;
                        end
                    end
                    MODE_IMM: begin
                        o_cmd.ld_b_imm = 1'b1;
                        n_state        = S_RDA;
                    end
                    default: begin
                        n_st    = ST_OK;
                        n_wr    = 1'b0;
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SRCV: begin
                o_cmd.sel_src = 1'b1;
                o_cmd.ld_ptr  = 1'b1;
                o_cmd.ptr_src = PTR_VAR;
                n_state       = S_RDB;
            end
            S_RDB: begin
                o_cmd.sel_src = 1'b1;
                o_cmd.mem_rd  = 1'b1;
                n_state       = S_LDB;
            end
            S_LDB: begin
                // take b and start the read of a
                o_cmd.ld_b    = 1'b1;
                o_cmd.sel_src = 1'b0;
                o_cmd.mem_rd  = 1'b1;
                n_state       = S_LDA;
            end
            S_RDA: begin
                o_cmd.sel_src = 1'b0;
                o_cmd.mem_rd  = 1'b1;
                n_state       = S_LDA;
            end
            S_LDA: begin
                o_cmd.ld_a = 1'b1;
                n_state    = S_EXE;
            end
            S_EXE: begin
                if (r_act inside {OP_DIV, OP_MOD}) begin
                    if (i_sts.b_zero) begin
                        n_st    = ST_DIVZERO;
                        n_wr    = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else begin
                    o_cmd.alu_ld = 1'b1;
                    n_st         = ST_OK;
                    n_wr         = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.alu_ld = 1'b1;
                    n_st         = ST_OK;
                    n_wr         = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.mem_wr = r_wr;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_OK;
            r_wr    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            r_wr    <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_action;
            r_dm  <= i_dest_mode;
            r_sm  <= i_src_mode;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bmie_dp.sv =====
// Datapath: variable table, data memory, ALU, divider and result register.
`default_nettype none
module bmie_dp
    import bmie_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF,
    parameter int MAX_VARS  = MAX_VARS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic [BYTE_W-1:0] i_dest_operand,
    input  wire logic [BYTE_W-1:0] i_src_operand,
    input  wire logic              i_cfg_we,
    input  wire logic [BYTE_W-1:0] i_cfg_first,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_wrote,
    output logic [BYTE_W-1:0]      o_write_address,
    output logic [BYTE_W-1:0]      o_write_value,
    output logic [STAT_W-1:0]      o_status
);

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int VIW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int VCW = $clog2(MAX_VARS + 1);
    localparam int CW  = (VCW > BYTE_W) ? VCW : BYTE_W;
    localparam logic [3:0] DIV_STEPS = 4'd8;

    logic [BYTE_W-1:0] r_dop, r_sop;
    logic [BYTE_W-1:0] r_addr, r_loc;
    logic [VCW-1:0]    r_cnt;
    logic [BYTE_W-1:0] r_nfl;
    logic [BYTE_W-1:0] r_a, r_b, r_res;
    logic [BYTE_W-1:0] r_quo, r_rem;
    logic [3:0]        r_div_cnt;
    logic              r_rd_ok;
    logic [MEM_DEPTH-1:0] r_vld;
    logic              r_ovld;

    logic [BYTE_W-1:0] var_rdata, mem_rdata, mem_val;
    logic [BYTE_W-1:0] idx, ptr_val, rd_ptr, alu;
    logic [2*BYTE_W-1:0] prod;
    logic [BYTE_W:0]   shifted, diff;
    logic              rd_in_rng, wr_in_rng, full;

    assign full = (r_cnt == VCW'(MAX_VARS));
    assign idx  = i_cmd.sel_src ? r_sop : r_dop;

    assign o_sts.dst_hit  = CW'(r_dop) < CW'(r_cnt);
    assign o_sts.src_hit  = CW'(r_sop) < CW'(r_cnt);
    assign o_sts.full     = full;
    assign o_sts.b_zero   = (r_b == '0);
    assign o_sts.div_busy = (r_div_cnt != '0);
    assign o_sts.out_free = !r_ovld || i_ready;

    bmie_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_VARS)
    ) u_var_tab (
        .i_clk   (i_clk),
        .i_we    (i_cmd.var_alloc),
        .i_waddr (r_cnt[VIW-1:0]),
        .i_wdata (r_nfl),
        .i_re    (i_cmd.var_rd),
        .i_raddr (idx[VIW-1:0]),
        .o_rdata (var_rdata)
    );

    assign rd_ptr    = i_cmd.sel_src ? r_loc : r_addr;
    assign rd_in_rng = (9'(rd_ptr) < 9'(MEM_DEPTH));
    assign wr_in_rng = (9'(r_addr) < 9'(MEM_DEPTH));

    bmie_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_data_mem (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_wr && wr_in_rng),
        .i_waddr (r_addr[AW-1:0]),
        .i_wdata (r_res),
        .i_re    (i_cmd.mem_rd),
        .i_raddr (rd_ptr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // unwritten and out-of-range cells read as zero
    assign mem_val = r_rd_ok ? mem_rdata : '0;

    always_comb begin
        case (i_cmd.ptr_src)
            PTR_OPND: ptr_val = idx;
            PTR_VAR:  ptr_val = var_rdata;
            default:  ptr_val = '0;
        endcase
    end

    assign prod    = r_a * r_b;
    assign shifted = {r_rem, r_quo[BYTE_W-1]};
    assign diff    = shifted - {1'b0, r_b};

    always_comb begin
        case (i_cmd.op)
            OP_ADD:  alu = r_a + r_b;
            OP_SUB:  alu = r_a - r_b;
            OP_MUL:  alu = prod[BYTE_W-1:0];
            OP_DIV:  alu = r_quo;
            OP_MOD:  alu = r_rem;
            default: alu = r_b;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_nfl     <= FIRST_VAR_RST;
            r_vld     <= '0;
            r_div_cnt <= '0;
            r_ovld    <= 1'b0;
        end else begin
            if (i_cfg_we && (r_cnt == '0)) begin
                r_nfl <= i_cfg_first;
            end
            if (i_cmd.var_alloc) begin
                r_cnt <= r_cnt + 1'b1;
                r_nfl <= r_nfl + 1'b1;
            end
            if (i_cmd.mem_wr && wr_in_rng) begin
                r_vld[r_addr[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.div_start) begin
                r_div_cnt <= DIV_STEPS;
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
            if (i_cmd.out_ld) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_dop <= i_dest_operand;
            r_sop <= i_src_operand;
        end
        if (i_cmd.ld_ptr || i_cmd.var_alloc) begin
            if (i_cmd.sel_src) begin
                r_loc <= i_cmd.var_alloc ? r_nfl : ptr_val;
            end else begin
                r_addr <= i_cmd.var_alloc ? r_nfl : ptr_val;
            end
        end
        if (i_cmd.mem_rd) begin
            r_rd_ok <= rd_in_rng && r_vld[rd_ptr[AW-1:0]];
        end
        if (i_cmd.ld_b) begin
            r_b <= mem_val;
        end else if (i_cmd.ld_b_imm) begin
            r_b <= r_sop;
        end
        if (i_cmd.ld_a) begin
            r_a <= mem_val;
        end
        if (i_cmd.div_start) begin
            r_quo <= r_a;
            r_rem <= '0;
        end else if (r_div_cnt != '0) begin
            if (!diff[BYTE_W]) begin
                r_rem <= diff[BYTE_W-1:0];
                r_quo <= {r_quo[BYTE_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[BYTE_W-1:0];
                r_quo <= {r_quo[BYTE_W-2:0], 1'b0};
            end
        end
        if (i_cmd.alu_ld) begin
            r_res <= alu;
        end
        if (i_cmd.out_ld) begin
            o_wrote         <= i_cmd.mem_wr && wr_in_rng;
            o_write_address <= (i_cmd.mem_wr && wr_in_rng) ? r_addr : '0;
            o_write_value   <= (i_cmd.mem_wr && wr_in_rng) ? r_res : '0;
            o_status        <= i_cmd.status;
        end
    end

    assign o_valid = r_ovld;

    a_no_alloc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.var_alloc |-> !full)
        else $error("variable allocated with full table");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_cnt) <= CW'(MAX_VARS))
        else $error("variable count beyond table size");

    a_div_idle_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> (r_div_cnt == '0))
        else $error("result loaded while divider busy");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> (!r_ovld || i_ready))
        else $error("result register overwritten");

    a_wrote_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld && i_cmd.mem_wr |=> (o_status == ST_OK))
        else $error("write with error status");

endmodule
`default_nettype wire

// ===== rtl/byte_memory_instruction_executor.sv =====
// Top level: config register, sequencer and datapath of the instruction executor.
// Opcodes 6 to 15 skip to the result stage; with source mode none nothing is computed;
// an ALU op reads the source and destination, a memory-read source going through S_RDB
// and S_LDB and each table hit through S_DSTV or S_SRCV; DIV/MOD then wait on the divider.
// Items are handled one at a time; the sequencer returns to idle once the result is
// loaded, so the next item can be accepted while that result waits in the output reg.
// Reset (sync, active low): memory reads as zero via per-cell valid bits, count zero.
`default_nettype none
module byte_memory_instruction_executor
    import bmie_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF,
    parameter int MAX_VARS  = MAX_VARS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [OPC_W-1:0]   i_action,
    input  wire logic [MODE_W-1:0]  i_dest_mode,
    input  wire logic [BYTE_W-1:0]  i_dest_operand,
    input  wire logic [MODE_W-1:0]  i_src_mode,
    input  wire logic [BYTE_W-1:0]  i_src_operand,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_wrote,
    output logic [BYTE_W-1:0]       o_write_address,
    output logic [BYTE_W-1:0]       o_write_value,
    output logic [STAT_W-1:0]       o_status
);

    logic [BYTE_W-1:0] r_first;
    logic              cfg_we;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_FIRST_VAR);
    assign prdata = (paddr[2] == REG_FIRST_VAR) ? PDATA_W'(r_first) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= FIRST_VAR_RST;
        end else if (cfg_we) begin
            r_first <= pwdata[BYTE_W-1:0];
        end
    end

    bmie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_dest_mode (i_dest_mode),
        .i_src_mode  (i_src_mode),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bmie_dp #(
        .MEM_DEPTH (MEM_DEPTH),
        .MAX_VARS  (MAX_VARS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_dest_operand  (i_dest_operand),
        .i_src_operand   (i_src_operand),
        .i_cfg_we        (cfg_we),
        .i_cfg_first     (pwdata[BYTE_W-1:0]),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_wrote         (o_wrote),
        .o_write_address (o_write_address),
        .o_write_value   (o_write_value),
        .o_status        (o_status)
    );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the byte memory instruction executor.
`default_nettype none
module tb_top;
    import bmie_pkg::*;

    localparam logic [OPC_W-1:0] OP_LBL   = 4'd6;
    localparam logic [OPC_W-1:0] OP_GOTO  = 4'd7;
    localparam logic [OPC_W-1:0] OP_PUT   = 4'd8;
    localparam logic [OPC_W-1:0] OP_SHOW  = 4'd9;
    localparam logic [OPC_W-1:0] OP_POINT = 4'd10;
    localparam logic [OPC_W-1:0] OP_RSVD  = 4'd15;

    localparam int NDIR       = 25;
    localparam int RAND_ITEMS = 360;
    localparam int HOLD_CYC   = 300;
    localparam int TAIL_CYC   = 25;
    localparam int LIMIT_CYC  = 500000;
    localparam int MAX_PRINT  = 50;

    typedef struct packed {
        logic [OPC_W-1:0]  act;
        logic [MODE_W-1:0] dm;
        logic [BYTE_W-1:0] dop;
        logic [MODE_W-1:0] sm;
        logic [BYTE_W-1:0] sop;
    } t_instr;

    typedef struct packed {
        logic              wrote;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] val;
        logic [STAT_W-1:0] status;
    } t_effect;

    typedef struct packed {
        t_instr  ins;
        logic    typed;
        t_effect eff;
    } t_row;

    // row tails: typed flag followed by the typed effect
    localparam logic [19:0] PRED = '0;
    localparam logic [19:0] NOP  = {1'b1, 1'b0, 8'd0, 8'd0, ST_OK};
    localparam logic [19:0] DIVZ = {1'b1, 1'b0, 8'd0, 8'd0, ST_DIVZERO};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [OPC_W-1:0] i_action = '0;
    logic [MODE_W-1:0] i_dest_mode = '0;
    logic [BYTE_W-1:0] i_dest_operand = '0;
    logic [MODE_W-1:0] i_src_mode = '0;
    logic [BYTE_W-1:0] i_src_operand = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_wrote;
    logic [BYTE_W-1:0] o_write_address;
    logic [BYTE_W-1:0] o_write_value;
    logic [STAT_W-1:0] o_status;

    // predictor state
    logic [BYTE_W-1:0] mem_img [MEM_DEPTH_DEF];
    logic [BYTE_W-1:0] var_loc [MAX_VARS_DEF];
    int                var_cnt;
    logic [BYTE_W-1:0] next_loc;
    logic [BYTE_W-1:0] first_var_reg;

    t_effect pending_effects [$];
    int      err_cnt = 0;
    int      cycles = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    logic    hold_req = 1'b0;
    int      hold_left = 0;

    t_row dir_rows [NDIR] = '{
        {OP_SET,   MODE_DIRECT, 8'd0,   MODE_IMM,    8'd255, 1'b1, 1'b1, 8'd0, 8'd255, ST_OK},
        {OP_ADD,   MODE_DIRECT, 8'd0,   MODE_IMM,    8'd1,   1'b1, 1'b1, 8'd0, 8'd0,   ST_OK},
        {OP_SUB,   MODE_DIRECT, 8'd1,   MODE_IMM,    8'd1,   1'b1, 1'b1, 8'd1, 8'd255, ST_OK},
        {OP_MUL,   MODE_DIRECT, 8'd1,   MODE_IMM,    8'd255, 1'b1, 1'b1, 8'd1, 8'd1,   ST_OK},
        {OP_DIV,   MODE_DIRECT, 8'd1,   MODE_IMM,    8'd0,   DIVZ},
        {OP_MOD,   MODE_DIRECT, 8'd1,   MODE_IMM,    8'd0,   DIVZ},
        {OP_SET,   MODE_DIRECT, 8'd2,   MODE_IMM,    8'd200, 1'b1, 1'b1, 8'd2, 8'd200, ST_OK},
        {OP_DIV,   MODE_DIRECT, 8'd2,   MODE_DIRECT, 8'd3,   DIVZ},
        {OP_DIV,   MODE_DIRECT, 8'd2,   MODE_IMM,    8'd7,   PRED},
        {OP_MOD,   MODE_DIRECT, 8'd2,   MODE_IMM,    8'd5,   PRED},
        {OP_SET,   MODE_IMM,    8'd255, MODE_DIRECT, 8'd2,   PRED},
        {OP_ADD,   MODE_NONE,   8'd77,  MODE_IMM,    8'd5,   PRED},
        {OP_SET,   MODE_VAR,    8'd0,   MODE_IMM,    8'd170, PRED},
        {OP_SET,   MODE_VAR,    8'd9,   MODE_IMM,    8'd85,  PRED},
        {OP_ADD,   MODE_VAR,    8'd0,   MODE_VAR,    8'd1,   PRED},
        {OP_SUB,   MODE_DIRECT, 8'd10,  MODE_NONE,   8'd0,   NOP},
        {OP_SET,   MODE_VAR,    8'd200, MODE_NONE,   8'd255, PRED},
        {OP_MUL,   MODE_DIRECT, 8'd4,   MODE_VAR,    8'd2,   PRED},
        {OP_LBL,   MODE_VAR,    8'd250, MODE_VAR,    8'd250, NOP},
        {OP_GOTO,  MODE_DIRECT, 8'd255, MODE_IMM,    8'd255, NOP},
        {OP_PUT,   MODE_IMM,    8'd0,   MODE_DIRECT, 8'd0,   NOP},
        {OP_SHOW,  MODE_NONE,   8'd255, MODE_NONE,   8'd255, NOP},
        {OP_POINT, MODE_VAR,    8'd0,   MODE_IMM,    8'd0,   NOP},
        {OP_RSVD,  MODE_NONE,   8'd255, MODE_NONE,   8'd255, NOP},
        {OP_SET,   MODE_DIRECT, 8'd255, MODE_DIRECT, 8'd255, PRED}
    };

    byte_memory_instruction_executor i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_dest_mode     (i_dest_mode),
        .i_dest_operand  (i_dest_operand),
        .i_src_mode      (i_src_mode),
        .i_src_operand   (i_src_operand),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_wrote         (o_wrote),
        .o_write_address (o_write_address),
        .o_write_value   (o_write_value),
        .o_status        (o_status)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_cnt < MAX_PRINT) begin
            $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
        end
        err_cnt++;
    endtask

    function automatic logic [BYTE_W-1:0] mem_rd(input logic [BYTE_W-1:0] addr);
        return (int'(addr) < MEM_DEPTH_DEF) ? mem_img[addr] : '0;
    endfunction

    // returns 0 when the index is new and the variable table is full
    function automatic bit resolve_var(input logic [BYTE_W-1:0] idx,
                                       output logic [BYTE_W-1:0] loc);
        loc = '0;
        if (int'(idx) < var_cnt) begin
            loc = var_loc[idx];
            return 1'b1;
        end
        if (var_cnt >= MAX_VARS_DEF) begin
            return 1'b0;
        end
        var_loc[var_cnt] = next_loc;
        loc = next_loc;
        var_cnt++;
        next_loc = next_loc + 8'd1;
        return 1'b1;
    endfunction

    function automatic t_effect apply_instr(input t_instr ins);
        t_effect eff;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] loc;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [15:0] r;
        eff = '0;
        eff.status = ST_OK;
        if (ins.act > OP_SET) begin
            return eff;
        end
        case (ins.dm)
            MODE_VAR: begin
                if (!resolve_var(ins.dop, addr)) begin
                    eff.status = ST_FULL;
                    return eff;
                end
            end
            MODE_NONE: addr = '0;
            default: addr = ins.dop;
        endcase
        case (ins.sm)
            MODE_DIRECT: b = mem_rd(ins.sop);
            MODE_VAR: begin
                if (!resolve_var(ins.sop, loc)) begin
                    eff.status = ST_FULL;
                    return eff;
                end
                b = mem_rd(loc);
            end
            MODE_IMM: b = ins.sop;
            default: return eff;
        endcase
        a = mem_rd(addr);
        case (ins.act)
            OP_ADD: r = 16'(a) + 16'(b);
            OP_SUB: r = 16'(a) - 16'(b);
            OP_MUL: r = 16'(a) * 16'(b);
            OP_DIV, OP_MOD: begin
                if (b == '0) begin
                    eff.status = ST_DIVZERO;
                    return eff;
                end
                r = (ins.act == OP_DIV) ? 16'(a / b) : 16'(a % b);
            end
            default: r = 16'(b);
        endcase
        if (int'(addr) < MEM_DEPTH_DEF) begin
            mem_img[addr] = r[7:0];
            eff.wrote = 1'b1;
            eff.addr = addr;
            eff.val = r[7:0];
        end
        return eff;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_addr();
        if ($urandom_range(0, 1) != 0) begin
            return 8'($urandom_range(0, 15));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_var(input int new_pct);
        if (var_cnt == 0 || $urandom_range(0, 99) < new_pct) begin
            return 8'($urandom_range(var_cnt, 255));
        end
        return 8'($urandom_range(0, var_cnt - 1));
    endfunction

    function automatic t_instr gen_instr(input int new_pct);
        t_instr ins;
        int r;
        ins.act = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 5))
                                                : 4'($urandom_range(6, 15));
        r = $urandom_range(0, 99);
        ins.dm = (r < 40) ? MODE_DIRECT : (r < 70) ? MODE_VAR : (r < 85) ? MODE_IMM : MODE_NONE;
        ins.dop = (ins.dm == MODE_VAR) ? pick_var(new_pct) : pick_addr();
        r = $urandom_range(0, 99);
        ins.sm = (r < 35) ? MODE_DIRECT : (r < 60) ? MODE_VAR : (r < 92) ? MODE_IMM : MODE_NONE;
        case (ins.sm)
            MODE_VAR: ins.sop = pick_var(new_pct);
            MODE_IMM: begin
                r = $urandom_range(0, 9);
                ins.sop = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
            end
            default: ins.sop = pick_addr();
        endcase
        return ins;
    endfunction

    // called at a rising edge; returns at the edge the item is taken
    task automatic send_instr(input t_instr ins, input logic typed, input t_effect want);
        t_effect eff;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= ins.act;
        i_dest_mode <= ins.dm;
        i_dest_operand <= ins.dop;
        i_src_mode <= ins.sm;
        i_src_operand <= ins.sop;
        do @(posedge i_clk); while (!o_ready);
        eff = apply_instr(ins);
        pending_effects.push_back(typed ? want : eff);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_effects.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic cfg_first_var(input logic [BYTE_W-1:0] loc);
        logic [PDATA_W-1:0] rd;
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'({REG_FIRST_VAR, 2'b00});
        pwdata <= PDATA_W'(loc);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        first_var_reg = loc;
        if (var_cnt == 0) begin
            next_loc = loc;
        end
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rd = prdata;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== PDATA_W'(first_var_reg)) begin
            report_mismatch("first_var_location readback", int'(rd), int'(first_var_reg));
        end
    endtask

    task automatic check_effect();
        t_effect want;
        if (pending_effects.size() == 0) begin
            report_mismatch("result with nothing pending", int'(o_write_address), 0);
            return;
        end
        want = pending_effects.pop_front();
        if (o_wrote !== want.wrote) begin
            report_mismatch("wrote", int'(o_wrote), int'(want.wrote));
        end
        if (o_write_address !== want.addr) begin
            report_mismatch("write_address", int'(o_write_address), int'(want.addr));
        end
        if (o_write_value !== want.val) begin
            report_mismatch("write_value", int'(o_write_value), int'(want.val));
        end
        if (o_status !== want.status) begin
            report_mismatch("status", int'(o_status), int'(want.status));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                check_effect();
            end
            if (hold_req) begin
                hold_req <= 1'b0;
                hold_left <= HOLD_CYC;
                i_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYC) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        foreach (mem_img[k]) mem_img[k] = '0;
        foreach (var_loc[k]) var_loc[k] = '0;
        var_cnt = 0;
        first_var_reg = FIRST_VAR_RST;
        next_loc = FIRST_VAR_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 9;
        rx_idle_pct = 57;
        cfg_first_var(8'h00);
        cfg_first_var(8'hFF);
        for (int k = 0; k < NDIR; k++) begin
            send_instr(dir_rows[k].ins, dir_rows[k].typed, dir_rows[k].eff);
        end

        cfg_first_var(8'h80);
        for (int k = 0; k < RAND_ITEMS; k++) begin
            send_instr(gen_instr(3), 1'b0, '0);
        end

        tx_idle_pct = 57;
        rx_idle_pct = 9;
        cfg_first_var(8'h00);
        for (int k = 0; k < RAND_ITEMS; k++) begin
            send_instr(gen_instr(3), 1'b0, '0);
        end

        // fill the variable table up to one free slot
        cfg_first_var(8'hFF);
        while (var_cnt < MAX_VARS_DEF - 1) begin
            send_instr({OP_SET, MODE_VAR, 8'(var_cnt), MODE_IMM, 8'($urandom_range(0, 255))},
                       1'b0, '0);
        end
        // destination takes the last slot, source then finds the table full
        send_instr({OP_ADD, MODE_VAR, 8'(var_cnt), MODE_VAR, 8'(var_cnt + 1)}, 1'b0, '0);
        send_instr({OP_SUB, MODE_VAR, 8'd255, MODE_VAR, 8'd0}, 1'b0, '0);
        send_instr({OP_SET, MODE_DIRECT, 8'd7, MODE_VAR, 8'd254}, 1'b0, '0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req <= 1'b1;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            send_instr(gen_instr(12), 1'b0, '0);
        end

        drain();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/bmie_pkg.sv
rtl/bmie_ram.sv
rtl/bmie_ctrl.sv
rtl/bmie_dp.sv
rtl/byte_memory_instruction_executor.sv
dv/tb_top.sv
